// ===== rtl/chunked_free_list_block_allocator_core_macros.svh =====
// Assertion macros shared by the allocator RTL.
`ifndef CHUNKED_FREE_LIST_BLOCK_ALLOCATOR_CORE_MACROS_SVH
`define CHUNKED_FREE_LIST_BLOCK_ALLOCATOR_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset only.
`define CFLBA_ASSERT_IMPL(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("cflba: same-cycle check failed");

// Next-cycle implication, checked out of reset only.
`define CFLBA_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("cflba: next-cycle check failed");

`endif

// ===== rtl/cflba_pkg.sv =====
// Constants, codes and types for the chunked free-list block allocator.
package cflba_pkg;

  // Chunk size and slot count are powers of two: handles split into slot and offset.
  localparam int CHUNK_BLOCKS = 64;
  localparam int MAX_CHUNKS   = 8;
  localparam int ALL_BLOCKS   = CHUNK_BLOCKS * MAX_CHUNKS;

  localparam int OFF_W   = $clog2(CHUNK_BLOCKS);
  localparam int SLOT_W  = $clog2(MAX_CHUNKS);
  localparam int ADDR_W  = OFF_W + SLOT_W;
  localparam int LINK_W  = $clog2(ALL_BLOCKS + 1);
  localparam int CNT_W   = $clog2(ALL_BLOCKS + 1);
  localparam int USE_W   = $clog2(CHUNK_BLOCKS + 1);
  localparam int SWEEP_W = $clog2(CHUNK_BLOCKS + 1);
  localparam int ACT_W   = $clog2(MAX_CHUNKS + 1);

  localparam int HANDLE_W        = 9;
  localparam int CMD_W           = 2;
  localparam int STATUS_W        = 2;
  localparam int CFG_W           = 4;
  localparam int CHUNK_LIMIT_RST = 8;

  localparam int IN_DATA_W  = ((HANDLE_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((HANDLE_W + 3 * CNT_W + 7) / 8) * 8;

  // End-of-list mark, one past the last block.
  localparam logic [LINK_W-1:0] LINK_END = LINK_W'(ALL_BLOCKS);

  localparam logic [CMD_W-1:0] CMD_ALLOC  = CMD_W'(0);
  localparam logic [CMD_W-1:0] CMD_FREE   = CMD_W'(1);
  localparam logic [CMD_W-1:0] CMD_SHRINK = CMD_W'(2);

  typedef enum logic [STATUS_W-1:0] {
    ST_OK,
    ST_NO_BLOCKS,
    ST_BAD_FREE,
    ST_SHRINK_REFUSED
  } status_e;

  typedef struct packed {
    logic              in_use;
    logic [LINK_W-1:0] link;
  } link_word_t;

endpackage

// ===== rtl/chunked_free_list_block_allocator_core.sv =====
// Top level of the chunked free-list block allocator.
// Fixed-size block allocator over up to MAX_CHUNKS chunk slots of CHUNK_BLOCKS
// blocks each; a block handle is slot * CHUNK_BLOCKS + offset. Free blocks sit
// on a LIFO linked list held in one link memory (ALL_BLOCKS words of next link
// plus in-use mark, one read and one write port, registered read).
// Every request returns exactly one result. Allocate and free each take
// a read of the link memory at the list head (or at the freed handle) and the
// write-back. An allocate that finds the list empty and may bring in a new
// chunk adds a sweep linking the chunk's blocks in ascending order, one word
// per cycle, then a fresh head read and a second decide step. A shrink that
// drops chunks adds a pipelined read/write sweep over chunk 0 rebuilding the
// list. After reset the block links chunk 0 with s_axis_tready_o low;
// configuration writes are taken at any time but should only be issued while
// no request is outstanding. The result sits in an output register, so the
// next request is taken while it waits; a request that finishes while the
// previous result is still unread holds until the output register frees.
`include "chunked_free_list_block_allocator_core_macros.svh"

module chunked_free_list_block_allocator_core
  import cflba_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration: chunk_limit
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_W-1:0]      cfg_data_i,      // [3:0] chunk_limit
  // Request stream
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,  // [8:0] block_handle, rest zero
  input  logic [CMD_W-1:0]      s_axis_tuser_i,  // [1:0] cmd
  // Result stream
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,  // [8:0] granted_block, [18:9] free_blocks,
                                                 // [28:19] total_blocks, [38:29] peak_in_use
  output logic [STATUS_W-1:0]   m_axis_tuser_o   // [1:0] status
);

  typedef enum logic [2:0] {
    S_INIT,   // link chunk 0 after reset
    S_IDLE,
    S_EXEC,   // memory data back, decide and write back
    S_LINK,   // link a newly brought-in chunk
    S_FETCH,  // re-read the head after a chunk was linked
    S_SHRINK  // rebuild the list over chunk 0
  } state_e;

  state_e                state_q, state_d;
  logic [SWEEP_W-1:0]    sweep_q, sweep_d;
  logic [LINK_W-1:0]     head_q, head_d;
  logic [CNT_W-1:0]      free_q, free_d;
  logic [CNT_W-1:0]      pool_q, pool_d;
  logic [CNT_W-1:0]      peak_q, peak_d;
  logic [ACT_W-1:0]      active_q, active_d;
  logic [USE_W-1:0]      chunk_use_q [MAX_CHUNKS];
  logic [USE_W-1:0]      chunk_use_d [MAX_CHUNKS];
  logic [CFG_W-1:0]      limit_q;

  logic                  out_valid_q, out_valid_d;
  status_e               out_status_q, out_status_d;
  logic [HANDLE_W-1:0]   out_granted_q, out_granted_d;
  logic [CNT_W-1:0]      out_free_q, out_free_d;
  logic [CNT_W-1:0]      out_total_q, out_total_d;
  logic [CNT_W-1:0]      out_peak_q, out_peak_d;

  // Request payload
  logic [CMD_W-1:0]      cmd_q;
  logic [ADDR_W-1:0]     handle_q;

  // Link memory
  link_word_t            link_mem [ALL_BLOCKS];
  link_word_t            rd_q;
  logic                  mem_re, mem_we;
  logic [ADDR_W-1:0]     mem_ra, mem_wa;
  link_word_t            mem_wd;

  logic                  in_acc;
  logic                  out_free_slot;
  logic [ACT_W-1:0]      lim;
  logic                  can_expand;
  logic                  upper_busy;
  logic                  free_ok;
  logic [SLOT_W-1:0]     link_slot;
  logic [LINK_W-1:0]     link_next;
  logic [SLOT_W-1:0]     head_slot;
  logic [SLOT_W-1:0]     handle_slot;
  logic [CNT_W-1:0]      used_now;
  logic                  emit;
  status_e               emit_status;
  logic [HANDLE_W-1:0]   emit_granted;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free_slot   = !out_valid_q || m_axis_tready_i;

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tdata_o  = OUT_DATA_W'({out_peak_q, out_total_q, out_free_q, out_granted_q});

  // Effective chunk limit: 0 acts as 1, clipped to the slot count.
  always_comb begin
    if (limit_q == '0) begin
      lim = ACT_W'(1);
    end else if (limit_q > CFG_W'(MAX_CHUNKS)) begin
      lim = ACT_W'(MAX_CHUNKS);
    end else begin
      lim = ACT_W'(limit_q);
    end
  end

  assign can_expand = active_q < lim;

  // Slots above 0 that are not active always hold a zero count.
  always_comb begin
    upper_busy = 1'b0;
    for (int c = 1; c < MAX_CHUNKS; c++) begin
      upper_busy = upper_busy | (chunk_use_q[c] != '0);
    end
  end

  assign head_slot   = head_q[ADDR_W-1:OFF_W];
  assign handle_slot = handle_q[ADDR_W-1:OFF_W];
  assign free_ok     = (CNT_W'(handle_q) < pool_q) && rd_q.in_use;

  assign link_slot = (state_q == S_LINK) ? active_q[SLOT_W-1:0] : '0;
  assign link_next = (sweep_q == SWEEP_W'(CHUNK_BLOCKS - 1)) ? LINK_END
                   : LINK_W'({link_slot, sweep_q[OFF_W-1:0]}) + LINK_W'(1);

  always_comb begin
    state_d       = state_q;
    sweep_d       = sweep_q;
    head_d        = head_q;
    free_d        = free_q;
    pool_d        = pool_q;
    peak_d        = peak_q;
    active_d      = active_q;
    chunk_use_d   = chunk_use_q;
    used_now      = '0;
    emit          = 1'b0;
    emit_status   = ST_OK;
    emit_granted  = '0;
    mem_re        = 1'b0;
    mem_ra        = head_q[ADDR_W-1:0];
    mem_we        = 1'b0;
    mem_wa        = head_q[ADDR_W-1:0];
    mem_wd        = '0;

    unique case (state_q)
      S_INIT, S_LINK: begin
        mem_we        = 1'b1;
        mem_wa        = {link_slot, sweep_q[OFF_W-1:0]};
        mem_wd.in_use = 1'b0;
        mem_wd.link   = link_next;
        sweep_d       = sweep_q + SWEEP_W'(1);
        if (sweep_q == SWEEP_W'(CHUNK_BLOCKS - 1)) begin
          sweep_d = '0;
          if (state_q == S_INIT) begin
            state_d = S_IDLE;
          end else begin
            head_d   = LINK_W'({active_q[SLOT_W-1:0], {OFF_W{1'b0}}});
            free_d   = free_q + CNT_W'(CHUNK_BLOCKS);
            pool_d   = pool_q + CNT_W'(CHUNK_BLOCKS);
            active_d = active_q + ACT_W'(1);
            state_d  = S_FETCH;
          end
        end
      end

      S_IDLE: begin
        if (in_acc) begin
          mem_re = 1'b1;
          mem_ra = (s_axis_tuser_i == CMD_FREE) ? ADDR_W'(s_axis_tdata_i[HANDLE_W-1:0])
                                                : head_q[ADDR_W-1:0];
          state_d = S_EXEC;
        end
      end

      S_FETCH: begin
        mem_re  = 1'b1;
        state_d = S_EXEC;
      end

      S_EXEC: begin
        if (out_free_slot) begin
          unique case (cmd_q)
            CMD_ALLOC: begin
              if (free_q == '0) begin
                if (can_expand) begin
                  sweep_d = '0;
                  state_d = S_LINK;
                end else begin
                  emit        = 1'b1;
                  emit_status = ST_NO_BLOCKS;
                end
              end else if (head_q >= LINK_END) begin
                emit        = 1'b1;
                emit_status = ST_NO_BLOCKS;
              end else begin
                mem_we        = 1'b1;
                mem_wd.in_use = 1'b1;
                mem_wd.link   = rd_q.link;
                head_d        = rd_q.link;
                free_d        = free_q - CNT_W'(1);
                chunk_use_d[head_slot] = chunk_use_q[head_slot] + USE_W'(1);
                used_now      = pool_q - free_d;
                if (used_now > peak_q) begin
                  peak_d = used_now;
                end
                emit         = 1'b1;
                emit_granted = head_q[HANDLE_W-1:0];
              end
            end
            CMD_FREE: begin
              emit = 1'b1;
              if (free_ok) begin
                mem_we        = 1'b1;
                mem_wa        = handle_q;
                mem_wd.in_use = 1'b0;
                mem_wd.link   = head_q;
                head_d        = LINK_W'(handle_q);
                free_d        = free_q + CNT_W'(1);
                chunk_use_d[handle_slot] = chunk_use_q[handle_slot] - USE_W'(1);
              end else begin
                emit_status = ST_BAD_FREE;
              end
            end
            CMD_SHRINK: begin
              if (active_q <= ACT_W'(1)) begin
                emit = 1'b1;
              end else if (upper_busy) begin
                emit        = 1'b1;
                emit_status = ST_SHRINK_REFUSED;
              end else begin
                // Counts restart; the sweep pushes each unused chunk-0 block.
                head_d   = LINK_END;
                free_d   = '0;
                pool_d   = CNT_W'(CHUNK_BLOCKS);
                active_d = ACT_W'(1);
                sweep_d  = '0;
                state_d  = S_SHRINK;
              end
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end

      S_SHRINK: begin
        // Read entry sweep_q while writing back entry sweep_q - 1.
        if (sweep_q != SWEEP_W'(CHUNK_BLOCKS)) begin
          mem_re = 1'b1;
          mem_ra = ADDR_W'(sweep_q);
        end
        if (sweep_q != SWEEP_W'(CHUNK_BLOCKS) || out_free_slot) begin
          if (sweep_q != '0 && !rd_q.in_use) begin
            mem_we        = 1'b1;
            mem_wa        = ADDR_W'(sweep_q - SWEEP_W'(1));
            mem_wd.in_use = 1'b0;
            mem_wd.link   = head_q;
            head_d        = LINK_W'(sweep_q - SWEEP_W'(1));
            free_d        = free_q + CNT_W'(1);
          end
          if (sweep_q == SWEEP_W'(CHUNK_BLOCKS)) begin
            emit    = 1'b1;
            sweep_d = '0;
          end else begin
            sweep_d = sweep_q + SWEEP_W'(1);
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (emit) begin
      state_d = S_IDLE;
    end

    out_valid_d   = out_valid_q && !m_axis_tready_i;
    out_status_d  = out_status_q;
    out_granted_d = out_granted_q;
    out_free_d    = out_free_q;
    out_total_d   = out_total_q;
    out_peak_d    = out_peak_q;
    if (emit) begin
      out_valid_d   = 1'b1;
      out_status_d  = emit_status;
      out_granted_d = emit_granted;
      out_free_d    = free_d;
      out_total_d   = pool_d;
      out_peak_d    = peak_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_INIT;
      sweep_q       <= '0;
      head_q        <= '0;
      free_q        <= CNT_W'(CHUNK_BLOCKS);
      pool_q        <= CNT_W'(CHUNK_BLOCKS);
      peak_q        <= '0;
      active_q      <= ACT_W'(1);
      chunk_use_q   <= '{default: '0};
      limit_q       <= CFG_W'(CHUNK_LIMIT_RST);
      out_valid_q   <= 1'b0;
      out_status_q  <= ST_OK;
      out_granted_q <= '0;
      out_free_q    <= '0;
      out_total_q   <= '0;
      out_peak_q    <= '0;
    end else begin
      state_q       <= state_d;
      sweep_q       <= sweep_d;
      head_q        <= head_d;
      free_q        <= free_d;
      pool_q        <= pool_d;
      peak_q        <= peak_d;
      active_q      <= active_d;
      chunk_use_q   <= chunk_use_d;
      if (cfg_valid_i && cfg_ready_o) begin
        limit_q <= cfg_data_i;
      end
      out_valid_q   <= out_valid_d;
      out_status_q  <= out_status_d;
      out_granted_q <= out_granted_d;
      out_free_q    <= out_free_d;
      out_total_q   <= out_total_d;
      out_peak_q    <= out_peak_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q    <= s_axis_tuser_i;
      handle_q <= ADDR_W'(s_axis_tdata_i[HANDLE_W-1:0]);
    end
  end

  // Link memory: synchronous read, one write port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      link_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_q <= link_mem[mem_ra];
    end
  end

  `CFLBA_ASSERT_IMPL(a_free_within_pool, clk_i, rst_ni, 1'b1, free_q <= pool_q)
  `CFLBA_ASSERT_IMPL(a_pool_tracks_chunks, clk_i, rst_ni, 1'b1,
                     pool_q == (CNT_W'(active_q) << OFF_W))
  `CFLBA_ASSERT_IMPL(a_active_in_range, clk_i, rst_ni, 1'b1,
                     active_q != '0 && active_q <= ACT_W'(MAX_CHUNKS))
  `CFLBA_ASSERT_NEXT(a_accept_reads_then_execs, clk_i, rst_ni, in_acc, state_q == S_EXEC)

endmodule

// ===== tb/chunked_free_list_block_allocator_core_test.sv =====
// Self-checking testbench for the chunked free-list block allocator core.
`timescale 1ns / 1ps

module chunked_free_list_block_allocator_core_test;
  import cflba_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 8;
  // Longest single request is a chunk sweep plus head read plus write-back.
  localparam int SETTLE_CYCLES = CHUNK_BLOCKS + 16;
  localparam int HOLD_CYCLES   = 400;
  localparam int BURST_LEN     = 40;
  localparam int NUM_PHASES    = 8;
  localparam int REPORT_LIMIT  = 10;
  localparam longint RUN_LIMIT_NS = 64'd800_000 * 2 * CLK_HALF;

  // cmd encoding not used by the block; it must answer ok and change nothing.
  localparam logic [CMD_W-1:0] CMD_NONE = CMD_W'(3);

  typedef struct packed {
    status_e             status;
    logic [HANDLE_W-1:0] granted;
    logic [CNT_W-1:0]    free_cnt;
    logic [CNT_W-1:0]    total_cnt;
    logic [CNT_W-1:0]    peak_cnt;
  } pool_report_t;

  // Shadow copy of the allocator: tracks the free list and counts, predicts replies.
  class pool_shadow;
    logic [LINK_W-1:0] next_link[ALL_BLOCKS];
    bit                used_mark[ALL_BLOCKS];
    int unsigned       chunk_used[MAX_CHUNKS];
    int unsigned       live_chunks;
    int unsigned       head;
    int unsigned       free_cnt;
    int unsigned       pool_cnt;
    int unsigned       peak;
    logic [CFG_W-1:0]  limit;
    pool_report_t      pool_reports[$];
    int                mismatches;

    function new();
      for (int i = 0; i < ALL_BLOCKS; i++) begin
        next_link[i] = LINK_END;
        used_mark[i] = 1'b0;
      end
      for (int c = 0; c < MAX_CHUNKS; c++) chunk_used[c] = 0;
      free_cnt    = 0;
      pool_cnt    = 0;
      peak        = 0;
      mismatches  = 0;
      limit       = CFG_W'(CHUNK_LIMIT_RST);
      link_chunk(0);
      live_chunks = 1;
    endfunction

    function void set_limit(logic [CFG_W-1:0] v);
      limit = v;
    endfunction

    function void link_chunk(int unsigned slot);
      int unsigned base;
      base = slot * CHUNK_BLOCKS;
      for (int i = 0; i < CHUNK_BLOCKS; i++)
        next_link[base+i] = (i + 1 < CHUNK_BLOCKS) ? LINK_W'(base + i + 1) : LINK_END;
      head     = base;
      free_cnt += CHUNK_BLOCKS;
      pool_cnt += CHUNK_BLOCKS;
    endfunction

    function status_e take_block(output logic [HANDLE_W-1:0] granted);
      int unsigned lim;
      int unsigned blk;
      granted = '0;
      lim = (limit == 0) ? 1 : limit;
      if (lim > MAX_CHUNKS) lim = MAX_CHUNKS;
      if (free_cnt == 0) begin
        if (live_chunks >= lim) return ST_NO_BLOCKS;
        link_chunk(live_chunks);
        live_chunks++;
      end
      blk = head;
      if (blk >= ALL_BLOCKS) return ST_NO_BLOCKS;
      used_mark[blk] = 1'b1;
      chunk_used[blk / CHUNK_BLOCKS]++;
      head = next_link[blk];
      free_cnt--;
      if (pool_cnt - free_cnt > peak) peak = pool_cnt - free_cnt;
      granted = HANDLE_W'(blk);
      return ST_OK;
    endfunction

    function status_e return_block(logic [HANDLE_W-1:0] blk);
      // Out of the active range, or not in use (covers double free).
      if (blk >= live_chunks * CHUNK_BLOCKS) return ST_BAD_FREE;
      if (!used_mark[blk]) return ST_BAD_FREE;
      used_mark[blk] = 1'b0;
      chunk_used[blk / CHUNK_BLOCKS]--;
      next_link[blk] = LINK_W'(head);
      head = blk;
      free_cnt++;
      return ST_OK;
    endfunction

    function status_e drop_chunks();
      int unsigned new_head;
      int unsigned count;
      new_head = ALL_BLOCKS;
      count    = 0;
      if (live_chunks <= 1) return ST_OK;
      for (int c = 1; c < live_chunks && c < MAX_CHUNKS; c++)
        if (chunk_used[c] > 0) return ST_SHRINK_REFUSED;
      // Rebuild from chunk 0 upwards, so the highest free block ends at the head.
      for (int i = 0; i < CHUNK_BLOCKS; i++) begin
        if (!used_mark[i]) begin
          next_link[i] = LINK_W'(new_head);
          new_head = i;
          count++;
        end
      end
      head        = new_head;
      live_chunks = 1;
      pool_cnt    = CHUNK_BLOCKS;
      free_cnt    = count;
      return ST_OK;
    endfunction

    function void apply_request(logic [CMD_W-1:0] cmd, logic [HANDLE_W-1:0] handle);
      pool_report_t rep;
      rep.granted = '0;
      rep.status  = ST_OK;
      case (cmd)
        CMD_ALLOC:  rep.status = take_block(rep.granted);
        CMD_FREE:   rep.status = return_block(handle);
        CMD_SHRINK: rep.status = drop_chunks();
        default:    rep.status = ST_OK;
      endcase
      rep.free_cnt  = CNT_W'(free_cnt);
      rep.total_cnt = CNT_W'(pool_cnt);
      rep.peak_cnt  = CNT_W'(peak);
      pool_reports.push_back(rep);
    endfunction

    function void check_reply(logic [OUT_DATA_W-1:0] data, logic [STATUS_W-1:0] st);
      pool_report_t want;
      pool_report_t got;
      got.status    = status_e'(st);
      got.granted   = data[HANDLE_W-1:0];
      got.free_cnt  = data[HANDLE_W +: CNT_W];
      got.total_cnt = data[HANDLE_W+CNT_W +: CNT_W];
      got.peak_cnt  = data[HANDLE_W+2*CNT_W +: CNT_W];
      if (pool_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: reply with no request waiting: st=%0d blk=%0d free=%0d tot=%0d pk=%0d",
                   $realtime, got.status, got.granted, got.free_cnt, got.total_cnt,
                   got.peak_cnt);
        return;
      end
      want = pool_reports.pop_front();
      if (want.status !== got.status || want.granted !== got.granted ||
          want.free_cnt !== got.free_cnt || want.total_cnt !== got.total_cnt ||
          want.peak_cnt !== got.peak_cnt) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: exp st=%0d blk=%0d free=%0d tot=%0d pk=%0d / got st=%0d blk=%0d free=%0d tot=%0d pk=%0d",
                   $realtime, want.status, want.granted, want.free_cnt, want.total_cnt,
                   want.peak_cnt, got.status, got.granted, got.free_cnt, got.total_cnt,
                   got.peak_cnt);
      end
    endfunction

    function int pending();
      return pool_reports.size();
    endfunction

    // Random block currently handed out; any handle if none is.
    function logic [HANDLE_W-1:0] pick_in_use();
      int start;
      int idx;
      start = $urandom_range(0, ALL_BLOCKS - 1);
      for (int k = 0; k < ALL_BLOCKS; k++) begin
        idx = (start + k) % ALL_BLOCKS;
        if (used_mark[idx]) return HANDLE_W'(idx);
      end
      return HANDLE_W'($urandom_range(0, ALL_BLOCKS - 1));
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_W-1:0]      cfg_data_i = '0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i = '0;
  logic [CMD_W-1:0]      s_axis_tuser_i = '0;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;
  logic [STATUS_W-1:0]   m_axis_tuser_o;

  pool_shadow sb;
  bit         steady = 1'b0;        // no idling on either side while set
  bit         hold_request = 1'b0;  // asks the result side for one long hold-off

  chunked_free_list_block_allocator_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 0;
  end

  // Offer one request from the falling edge, hold until taken, then log it.
  task automatic issue_request(input logic [CMD_W-1:0] cmd, input logic [HANDLE_W-1:0] handle);
    @(negedge clk_i);
    while (!steady && $urandom_range(0, 99) < 8) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= IN_DATA_W'(handle);
    s_axis_tuser_i  <= cmd;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    sb.apply_request(cmd, handle);
  endtask

  // Register writes only once every reply is back and the block has settled.
  task automatic write_limit(input logic [CFG_W-1:0] value);
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.set_limit(value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // One random request; alloc_pct biases towards filling or emptying the pool.
  task automatic random_request(input int alloc_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < 2)
      issue_request(CMD_NONE, HANDLE_W'($urandom));
    else if (r < 5)
      issue_request(CMD_SHRINK, HANDLE_W'($urandom));
    else if ($urandom_range(0, 99) < alloc_pct)
      issue_request(CMD_ALLOC, HANDLE_W'($urandom));
    else if ($urandom_range(0, 99) < 85)
      issue_request(CMD_FREE, sb.pick_in_use());
    else
      issue_request(CMD_FREE, HANDLE_W'($urandom));  // mostly bad or double frees
  endtask

  // Result side: random back-pressure, one long hold-off on request.
  int hold_left = 0;
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= steady || ($urandom_range(0, 99) >= 8);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      sb.check_reply(m_axis_tdata_o, m_axis_tuser_o);
  end

  // Main sequence: directed corners, then phases over several chunk limits.
  initial begin
    logic [CFG_W-1:0] phase_limit[NUM_PHASES];
    int               phase_items[NUM_PHASES];
    int               bias;
    sb = new();
    phase_limit = '{CFG_W'(8), CFG_W'(1), CFG_W'(15), CFG_W'(0),
                    CFG_W'(3), CFG_W'(8), CFG_W'(2), CFG_W'(8)};
    phase_items = '{300, 200, 600, 150, 250, 300, 150, 250};
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed corners at the reset limit.
    issue_request(CMD_FREE, HANDLE_W'(0));            // free of a block never handed out
    issue_request(CMD_FREE, HANDLE_W'(ALL_BLOCKS-1)); // handle beyond the active chunk
    issue_request(CMD_NONE, HANDLE_W'(ALL_BLOCKS-1)); // unused command
    issue_request(CMD_SHRINK, '0);                    // shrink with a single chunk
    issue_request(CMD_ALLOC, HANDLE_W'(ALL_BLOCKS-1));
    issue_request(CMD_ALLOC, '0);
    issue_request(CMD_FREE, HANDLE_W'(0));
    issue_request(CMD_FREE, HANDLE_W'(0));            // double free
    issue_request(CMD_FREE, HANDLE_W'(1));
    issue_request(CMD_ALLOC, '0);
    issue_request(CMD_SHRINK, HANDLE_W'(ALL_BLOCKS-1));
    issue_request(CMD_NONE, '0);
    issue_request(CMD_ALLOC, '0);
    issue_request(CMD_FREE, HANDLE_W'(CHUNK_BLOCKS)); // slot 1 not active yet

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_limit(phase_limit[p]);
      steady = (p == 4);
      if (p == 5) hold_request = 1'b1;
      bias = 50;
      for (int n = 0; n < phase_items[p]; n++) begin
        if (n % BURST_LEN == 0) begin
          case ($urandom_range(0, 4))
            0: bias = 90;
            1: bias = 70;
            2: bias = 50;
            3: bias = 30;
            default: bias = 10;
          endcase
        end
        // Phase 2 runs the pool to exhaustion before it drains.
        if (p == 2) bias = (n < phase_items[p] - 60) ? 93 : 5;
        random_request(bias);
      end
      steady = 1'b0;
    end

    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
